// ===== src/multipart_body_splitter_macros.svh =====
// Assertion macros shared by the splitter RTL.
`ifndef MULTIPART_BODY_SPLITTER_MACROS_SVH
`define MULTIPART_BODY_SPLITTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define MBS_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("splitter assertion failed");

// Next-cycle implication.
`define MBS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("splitter assertion failed");

`else

`define MBS_ASSERT_IMP(name, clk, rst, ante, cons)
`define MBS_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== src/mbs_pkg.sv =====
// Shared types and constants for the multipart body splitter.
`timescale 1ns / 1ps

package mbs_pkg;

  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int LEN_W          = 6;
  localparam int NUM_WORDS      = 7;
  localparam int BOUNDARY_BYTES = 56;
  localparam int PART_NUM_W     = 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_BOUNDARY_LEN    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BOUNDARY_WORD_0 = 3'd1;

  localparam logic [1:0] KIND_HEADER   = 2'd0;
  localparam logic [1:0] KIND_CONTENT  = 2'd1;
  localparam logic [1:0] KIND_PART_END = 2'd2;
  localparam logic [1:0] KIND_MSG_END  = 2'd3;

  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] BYTE_DASH = 8'h2D;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       msg_start;
  } in_t;

  typedef struct packed {
    logic [7:0]            out_byte;
    logic [1:0]            kind;
    logic [PART_NUM_W-1:0] part_number;
    logic                  first_of_part;
    logic                  header_last;
  } result_t;

endpackage

// ===== src/multipart_body_splitter.sv =====
// Top level of the multipart body splitter.
//
//   channel  dir  handshake                payload
//   in       in   in_valid / in_ready      in_data  (mbs_pkg::in_t)
//   out      out  out_valid / out_ready    out_data (mbs_pkg::result_t)
//   cfg      in   cfg_write                cfg_index, cfg_data
//
// One byte per cycle in while in_ready is high, at most one result per cycle
// out; the limit is the lane compare of the window against the pattern in
// mbs_front. A result is queued in the cycle its byte is accepted and is then
// registered onto out_data by mbs_back; out_ready low can hold it back.
// Reset is synchronous; the window needs no clearing pass, as its occupancy is
// a thermometer that reset empties. A boundary write is used by the next byte.
// A four-entry queue decouples the sides: in_ready drops only when it is full.
`timescale 1ns / 1ps

module multipart_body_splitter #(
  parameter int MAX_BOUNDARY = 56,
  parameter int WINDOW_DEPTH = 64,
  parameter int PART_BITS    = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mbs_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mbs_pkg::result_t                  out_data,
  input  logic                              cfg_write,
  input  logic [mbs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mbs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [WINDOW_DEPTH-1:0][7:0] pat_bytes;
  logic [WINDOW_DEPTH-1:0]      pre_mask;
  logic [WINDOW_DEPTH-1:0]      cont_mask;
  logic                         cmd_valid;
  mbs_pkg::result_t             cmd;
  logic                         q_space;
  logic                         q_valid;
  logic                         q_pop;
  mbs_pkg::result_t             q_data;

  mbs_pattern #(
    .MAX_BOUNDARY (MAX_BOUNDARY),
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_pattern (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pat_bytes (pat_bytes),
    .pre_mask  (pre_mask),
    .cont_mask (cont_mask)
  );

  mbs_front #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .PART_BITS    (PART_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .pat_bytes (pat_bytes),
    .pre_mask  (pre_mask),
    .cont_mask (cont_mask),
    .cmd_ready (q_space),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  mbs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_valid),
    .push_data (cmd),
    .space     (q_space),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_data)
  );

  mbs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== src/mbs_pattern.sv =====
// Boundary registers and the lane-aligned closing pattern they produce.
`timescale 1ns / 1ps

module mbs_pattern #(
  parameter int MAX_BOUNDARY = 56,
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [mbs_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [mbs_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic [WINDOW_DEPTH-1:0][7:0]         pat_bytes,
  output logic [WINDOW_DEPTH-1:0]              pre_mask,
  output logic [WINDOW_DEPTH-1:0]              cont_mask
);

  localparam int LEN_LIMIT = (MAX_BOUNDARY < WINDOW_DEPTH - 4) ? MAX_BOUNDARY : WINDOW_DEPTH - 4;
  localparam int IDX_W     = $clog2(WINDOW_DEPTH) + 1;
  localparam int BI_W      = $clog2(mbs_pkg::BOUNDARY_BYTES);

  logic [mbs_pkg::LEN_W-1:0]                          len;
  logic [mbs_pkg::LEN_W-1:0]                          len_next;
  logic [mbs_pkg::NUM_WORDS-1:0][mbs_pkg::CFG_DATA_W-1:0] words;
  logic [mbs_pkg::NUM_WORDS-1:0][mbs_pkg::CFG_DATA_W-1:0] words_next;
  logic [mbs_pkg::BOUNDARY_BYTES-1:0][7:0]            bnd;
  logic [mbs_pkg::LEN_W-1:0]                          eff_len;
  logic [WINDOW_DEPTH-1:0][7:0]                       lane_bytes;
  logic [WINDOW_DEPTH-1:0]                            lane_pre;
  logic [WINDOW_DEPTH-1:0]                            lane_cont;

  always_comb begin
    len_next   = len;
    words_next = words;
    if (rst) begin
      len_next   = mbs_pkg::LEN_W'(1);
      words_next = '0;
    end else if (cfg_write) begin
      if (cfg_index == mbs_pkg::REG_BOUNDARY_LEN) begin
        len_next = cfg_data[mbs_pkg::LEN_W-1:0];
      end else begin
        words_next[cfg_index - mbs_pkg::REG_BOUNDARY_WORD_0] = cfg_data;
      end
    end
  end

  assign bnd = words_next;

  // Lane j holds the pattern byte expected j places back from the newest byte.
  always_comb begin
    logic [IDX_W-1:0] tot;
    logic [IDX_W-1:0] pos;
    logic [BI_W-1:0]  pidx;
    if (len_next == '0) begin
      eff_len = mbs_pkg::LEN_W'(1);
    end else if (len_next > mbs_pkg::LEN_W'(LEN_LIMIT)) begin
      eff_len = mbs_pkg::LEN_W'(LEN_LIMIT);
    end else begin
      eff_len = len_next;
    end
    tot = IDX_W'(eff_len) + IDX_W'(4);
    for (int j = 0; j < WINDOW_DEPTH; j++) begin
      lane_cont[j]  = IDX_W'(j) < tot;
      lane_pre[j]   = IDX_W'(j) < (tot - IDX_W'(2));
      pos           = tot - IDX_W'(1) - IDX_W'(j);
      pidx          = BI_W'(pos - IDX_W'(4));
      lane_bytes[j] = '0;
      if (lane_cont[j]) begin
        if (pos == IDX_W'(0)) begin
          lane_bytes[j] = mbs_pkg::BYTE_CR;
        end else if (pos == IDX_W'(1)) begin
          lane_bytes[j] = mbs_pkg::BYTE_LF;
        end else if (pos < IDX_W'(4)) begin
          lane_bytes[j] = mbs_pkg::BYTE_DASH;
        end else begin
          lane_bytes[j] = bnd[pidx];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    len       <= len_next;
    words     <= words_next;
    pat_bytes <= lane_bytes;
    pre_mask  <= lane_pre;
    cont_mask <= lane_cont;
  end

endmodule

// ===== src/mbs_front.sv =====
// Front end: byte window, parallel pattern compare and parse phase control.
`timescale 1ns / 1ps
`include "multipart_body_splitter_macros.svh"

module mbs_front #(
  parameter int WINDOW_DEPTH = 64,
  parameter int PART_BITS    = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  mbs_pkg::in_t                 in_data,
  input  logic [WINDOW_DEPTH-1:0][7:0] pat_bytes,
  input  logic [WINDOW_DEPTH-1:0]      pre_mask,
  input  logic [WINDOW_DEPTH-1:0]      cont_mask,
  input  logic                         cmd_ready,
  output logic                         cmd_valid,
  output mbs_pkg::result_t             cmd
);

  localparam logic [2:0] PH_PREAMBLE = 3'd0;
  localparam logic [2:0] PH_SKIP_A   = 3'd1;
  localparam logic [2:0] PH_SKIP_B   = 3'd2;
  localparam logic [2:0] PH_HEADER   = 3'd3;
  localparam logic [2:0] PH_CONTENT  = 3'd4;
  localparam logic [2:0] PH_DONE     = 3'd5;

  localparam logic [31:0] HDR_END = 32'h0D0A0D0A;

  logic [2:0]                   phase, phase_next;
  logic [WINDOW_DEPTH-1:0][7:0] win, win_next;
  logic [WINDOW_DEPTH-1:0]      fill, fill_next;  // occupancy, thermometer coded
  logic [31:0]                  header_tail, header_tail_next;
  logic [PART_BITS-1:0]         part_count, part_count_next;
  logic                         first_pending, first_pending_next;
  logic                         dash_seen, dash_seen_next;

  logic                         accept;
  logic [7:0]                   b;
  logic [2:0]                   ph_cur;
  logic [WINDOW_DEPTH-1:0]      fill_cur;
  logic [31:0]                  tail_cur;
  logic [PART_BITS-1:0]         part_cur;
  logic                         first_cur;
  logic                         dash_cur;
  logic [WINDOW_DEPTH-1:0][7:0] win_push;
  logic [WINDOW_DEPTH-1:0]      fill_push;
  logic [WINDOW_DEPTH-1:0]      eq;
  logic [WINDOW_DEPTH-1:0]      sel;
  logic                         pre_hit;
  logic                         cont_hit;
  logic                         cont_full;
  logic [7:0]                   oldest;
  logic [31:0]                  tail_shift;

  assign accept   = in_valid && cmd_ready;
  assign in_ready = cmd_ready;
  assign b        = in_data.in_byte;

  // A new message start discards all parse state before this byte.
  always_comb begin
    ph_cur    = in_data.msg_start ? PH_PREAMBLE : phase;
    fill_cur  = in_data.msg_start ? '0 : fill;
    tail_cur  = in_data.msg_start ? '0 : header_tail;
    part_cur  = in_data.msg_start ? '0 : part_count;
    first_cur = in_data.msg_start ? 1'b0 : first_pending;
    dash_cur  = in_data.msg_start ? 1'b0 : dash_seen;
  end

  always_comb begin
    win_push[0] = b;
    for (int j = 1; j < WINDOW_DEPTH; j++) begin
      win_push[j] = win[j-1];
    end
    fill_push = {fill_cur[WINDOW_DEPTH-2:0], 1'b1};
    for (int j = 0; j < WINDOW_DEPTH; j++) begin
      eq[j] = (win_push[j] == pat_bytes[j]) && fill_push[j];
    end
    pre_hit   = &(eq | ~pre_mask);
    cont_hit  = &(eq | ~cont_mask);
    cont_full = &(fill_push | ~cont_mask);
    sel       = fill_push & ~(fill_push >> 1);
    oldest    = '0;
    for (int j = 0; j < WINDOW_DEPTH; j++) begin
      oldest = oldest | (win_push[j] & {8{sel[j]}});
    end
    tail_shift = {tail_cur[23:0], b};
  end

  always_comb begin
    phase_next         = phase;
    win_next           = win;
    fill_next          = fill;
    header_tail_next   = header_tail;
    part_count_next    = part_count;
    first_pending_next = first_pending;
    dash_seen_next     = dash_seen;
    cmd_valid          = 1'b0;
    cmd                = '0;
    cmd.part_number    = mbs_pkg::PART_NUM_W'(part_cur);
    if (accept) begin
      phase_next         = ph_cur;
      fill_next          = fill_cur;
      header_tail_next   = tail_cur;
      part_count_next    = part_cur;
      first_pending_next = first_cur;
      dash_seen_next     = dash_cur;
      case (ph_cur)
        PH_PREAMBLE: begin
          win_next  = win_push;
          fill_next = fill_push;
          if (pre_hit) begin
            fill_next  = '0;
            phase_next = PH_SKIP_A;
          end
        end
        PH_SKIP_A: begin
          dash_seen_next = (b == mbs_pkg::BYTE_DASH);
          phase_next     = PH_SKIP_B;
        end
        PH_SKIP_B: begin
          dash_seen_next = 1'b0;
          if (dash_cur && b == mbs_pkg::BYTE_DASH) begin
            phase_next = PH_DONE;
            cmd_valid  = 1'b1;
            cmd.kind   = mbs_pkg::KIND_MSG_END;
          end else begin
            header_tail_next   = '0;
            first_pending_next = 1'b1;
            phase_next         = PH_HEADER;
          end
        end
        PH_HEADER: begin
          first_pending_next = 1'b0;
          header_tail_next   = tail_shift;
          cmd_valid          = 1'b1;
          cmd.kind           = mbs_pkg::KIND_HEADER;
          cmd.out_byte       = b;
          cmd.first_of_part  = first_cur;
          cmd.header_last    = (tail_shift == HDR_END);
          if (tail_shift == HDR_END) begin
            fill_next  = '0;
            phase_next = PH_CONTENT;
          end
        end
        PH_CONTENT: begin
          win_next  = win_push;
          fill_next = fill_push;
          if (cont_hit) begin
            fill_next  = '0;
            phase_next = PH_SKIP_A;
            cmd_valid  = 1'b1;
            cmd.kind   = mbs_pkg::KIND_PART_END;
            if (part_cur != '1) begin
              part_count_next = part_cur + 1'b1;
            end
          end else if (cont_full) begin
            fill_next    = fill_push >> 1;
            cmd_valid    = 1'b1;
            cmd.kind     = mbs_pkg::KIND_CONTENT;
            cmd.out_byte = oldest;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_PREAMBLE;
      fill          <= '0;
      header_tail   <= '0;
      part_count    <= '0;
      first_pending <= 1'b0;
      dash_seen     <= 1'b0;
    end else begin
      phase         <= phase_next;
      fill          <= fill_next;
      header_tail   <= header_tail_next;
      part_count    <= part_count_next;
      first_pending <= first_pending_next;
      dash_seen     <= dash_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    win <= win_next;
  end

  `MBS_ASSERT_IMP(a_fill_thermo, clk, rst, 1'b1, $countones(fill ^ (fill >> 1)) <= 1)
  `MBS_ASSERT_NEXT(a_msg_end_done, clk, rst, cmd_valid && cmd.kind == mbs_pkg::KIND_MSG_END, phase == PH_DONE)
  `MBS_ASSERT_NEXT(a_hdr_to_content, clk, rst, cmd_valid && cmd.header_last, phase == PH_CONTENT && fill == '0)

endmodule

// ===== src/mbs_queue.sv =====
// Short result queue between the front end and the output stage.
`timescale 1ns / 1ps
`include "multipart_body_splitter_macros.svh"

module mbs_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mbs_pkg::result_t push_data,
  output logic             space,
  output logic             pop_valid,
  input  logic             pop,
  output mbs_pkg::result_t pop_data
);

  mbs_pkg::result_t              mem [mbs_pkg::QUEUE_DEPTH];
  logic [mbs_pkg::QPTR_W-1:0]    wr_ptr;
  logic [mbs_pkg::QPTR_W-1:0]    rd_ptr;
  logic [mbs_pkg::QCNT_W-1:0]    count;

  assign space     = count != mbs_pkg::QCNT_W'(mbs_pkg::QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `MBS_ASSERT_IMP(a_no_overflow, clk, rst, push, space)
  `MBS_ASSERT_IMP(a_no_underflow, clk, rst, pop, pop_valid)

endmodule

// ===== src/mbs_back.sv =====
// Output stage: registered result with valid/ready towards the consumer.
`timescale 1ns / 1ps

module mbs_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  mbs_pkg::result_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output mbs_pkg::result_t out_data
);

  // Reload when the queue holds a result and the register is empty or its transaction completes now.
  assign q_pop = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data <= q_data;
    end
  end

endmodule
